/* rtl/amt_pkg.sv */
// shared types and constants for the adjacency matrix minimum edge tracker
package amt_pkg;

    localparam int VTX_W        = 6;
    localparam int WGT_W        = 31;
    localparam int VCNT_W       = 7;
    localparam int ENTRY_W      = WGT_W + 1;
    localparam int ADDR_FULL_W  = 2 * VTX_W;
    localparam int RESULT_LIMIT = 16;
    localparam int LCNT_W       = 5;
    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_DIRECTED     = 1'b0,
        CFG_VERTEX_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR1,
        S_WR2,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LIST_RD,
        S_LIST_CHK,
        S_LIST_END,
        S_RESP,
        S_QUERY
    } t_state;

    typedef struct packed {
        t_cmd             command;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
        logic [WGT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [WGT_W-1:0] weight_out;
        logic             found;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [ENTRY_W-1:0] wdata;
    } t_mem_ctrl;

endpackage

/* rtl/amt_edge_mem.sv */
// single port edge store with registered read data
module amt_edge_mem
    import amt_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               i_clk,
    input  t_mem_ctrl          i_ctrl,
    input  logic [AW-1:0]      i_addr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_addr] <= i_ctrl.wdata;
        end
        if (i_ctrl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/adjacency_matrix_min_edge_tracker.sv */
// weighted adjacency matrix with minimum edge record, top level
//
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_stall       | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall     | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we, i_cfg_index         | i_cfg_data (7 bits)
//
// one item at a time: add and remove write the entry, plus its mirror when
// undirected, then answer; query answers from the record. a remove that hits
// the recorded minimum rescans the active square through the single memory
// port, a read and a check per entry. neighbour listing walks one row, a read
// and a check per column, then a closing step, plus output waits. after reset a
// clearing pass writes every entry with o_in_stall high. the output register
// frees the core from downstream stalls except when a new result is ready and
// the register is still held.
module adjacency_matrix_min_edge_tracker
    import amt_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [VCNT_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [VCNT_W-1:0] MAX_V = VCNT_W'(MAX_VERTICES);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [VTX_W-1:0]   r_v1, n_v1, r_v2, n_v2;
    logic [WGT_W-1:0]   r_w, n_w;
    logic [VTX_W-1:0]   r_row, n_row, r_col, n_col;
    logic [LCNT_W-1:0]  r_cnt, n_cnt;
    logic               r_pend_valid, n_pend_valid;
    logic [VTX_W-1:0]   r_pend_col, n_pend_col;
    logic [WGT_W-1:0]   r_pend_w, n_pend_w;
    logic               r_hit, n_hit;
    logic               r_resp_found, n_resp_found;
    logic [VTX_W-1:0]   r_min_first, n_min_first, r_min_second, n_min_second;
    logic [WGT_W-1:0]   r_min_weight, n_min_weight;
    logic               r_min_present, n_min_present;
    logic               r_directed;
    logic [VCNT_W-1:0]  r_vcount;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;

    logic [VCNT_W-1:0]  act_n;
    logic [VCNT_W-1:0]  act_last;
    logic               out_free;
    t_mem_ctrl          mem_ctrl;
    logic [VTX_W-1:0]   mem_row, mem_col;
    logic [ADDR_FULL_W-1:0] addr_full;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [WGT_W-1:0]   rd_w;
    logic               rd_present;
    logic [WGT_W-1:0]   cmp_lhs;
    logic               cmp_lt, cmp_eq;
    logic               wr_done, wr_hit;
    logic               col_last, row_last;
    logic               in_v1_ok, in_v2_ok;

    assign act_n    = (r_vcount < MAX_V) ? r_vcount : MAX_V;
    assign act_last = act_n - VCNT_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_w       = rd_data[WGT_W-1:0];
    assign rd_present = rd_data[ENTRY_W-1];
    assign col_last = ({1'b0, r_col} == act_last);
    assign row_last = ({1'b0, r_row} == act_last);
    assign in_v1_ok = ({1'b0, i_in_item.from_vertex} < act_n);
    assign in_v2_ok = ({1'b0, i_in_item.to_vertex} < act_n);

    // shared weight comparator, against the recorded minimum
    assign cmp_lt = cmp_lhs < r_min_weight;
    assign cmp_eq = cmp_lhs == r_min_weight;

    assign addr_full = ADDR_FULL_W'(mem_row) * ADDR_FULL_W'(MAX_VERTICES)
                     + ADDR_FULL_W'(mem_col);
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr_addr : addr_full[AW-1:0];

    amt_edge_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctrl  (mem_ctrl),
        .i_addr  (mem_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_v1          = r_v1;
        n_v2          = r_v2;
        n_w           = r_w;
        n_row         = r_row;
        n_col         = r_col;
        n_cnt         = r_cnt;
        n_pend_valid  = r_pend_valid;
        n_pend_col    = r_pend_col;
        n_pend_w      = r_pend_w;
        n_hit         = r_hit;
        n_resp_found  = r_resp_found;
        n_min_first   = r_min_first;
        n_min_second  = r_min_second;
        n_min_weight  = r_min_weight;
        n_min_present = r_min_present;
        n_clr_addr    = r_clr_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_item    = r_out_item;
        mem_ctrl      = '0;
        mem_row       = r_v1;
        mem_col       = r_v2;
        cmp_lhs       = rd_w;
        wr_done       = 1'b0;
        wr_hit        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_ctrl.we = 1'b1;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_in_item.command;
                    n_v1         = i_in_item.from_vertex;
                    n_v2         = i_in_item.to_vertex;
                    n_w          = i_in_item.edge_weight;
                    n_row        = i_in_item.from_vertex;
                    n_col        = '0;
                    n_cnt        = '0;
                    n_pend_valid = 1'b0;
                    unique case (i_in_item.command)
                        CMD_ADD, CMD_REMOVE: begin
                            if (in_v1_ok && in_v2_ok) begin
                                n_state = S_WR1;
                            end else begin
                                n_resp_found = 1'b0;
                                n_state      = S_RESP;
                            end
                        end
                        CMD_QUERY: n_state = S_QUERY;
                        CMD_LIST:  n_state = in_v1_ok ? S_LIST_RD : S_LIST_END;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_WR1: begin
                mem_ctrl.we    = 1'b1;
                mem_ctrl.wdata = (r_cmd == CMD_ADD) ? {1'b1, r_w} : '0;
                cmp_lhs        = r_w;
                if (r_cmd == CMD_ADD && (!r_min_present || cmp_lt || cmp_eq)) begin
                    n_min_present = 1'b1;
                    n_min_first   = r_v1;
                    n_min_second  = r_v2;
                    n_min_weight  = r_w;
                end
                n_hit = r_min_present &&
                        ((r_v1 == r_min_first && r_v2 == r_min_second) ||
                         (r_v2 == r_min_first && r_v1 == r_min_second));
                if (r_directed) begin
                    wr_done = 1'b1;
                    wr_hit  = n_hit;
                end else begin
                    n_state = S_WR2;
                end
            end
            S_WR2: begin
                // mirrored entry
                mem_ctrl.we    = 1'b1;
                mem_ctrl.wdata = (r_cmd == CMD_ADD) ? {1'b1, r_w} : '0;
                mem_row        = r_v2;
                mem_col        = r_v1;
                wr_done        = 1'b1;
                wr_hit         = r_hit;
            end
            S_SCAN_RD: begin
                mem_ctrl.re = 1'b1;
                mem_row     = r_row;
                mem_col     = r_col;
                n_state     = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (rd_present && (!r_min_present || cmp_lt)) begin
                    n_min_present = 1'b1;
                    n_min_first   = r_row;
                    n_min_second  = r_col;
                    n_min_weight  = rd_w;
                end
                n_state = S_SCAN_RD;
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_resp_found = 1'b1;
                        n_state      = S_RESP;
                    end else begin
                        n_row = r_row + VTX_W'(1);
                    end
                end else begin
                    n_col = r_col + VTX_W'(1);
                end
            end
            S_LIST_RD: begin
                mem_ctrl.re = 1'b1;
                mem_row     = r_row;
                mem_col     = r_col;
                n_state     = S_LIST_CHK;
            end
            S_LIST_CHK: begin
                // one item is held back so the final one can carry last
                if (!(rd_present && r_pend_valid && !out_free)) begin
                    if (rd_present && r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{vertex_a: r_pend_col, vertex_b: '0,
                                        weight_out: r_pend_w, found: 1'b1,
                                        last: 1'b0};
                    end
                    if (rd_present) begin
                        n_pend_valid = 1'b1;
                        n_pend_col   = r_col;
                        n_pend_w     = rd_w;
                        n_cnt        = r_cnt + LCNT_W'(1);
                    end
                    if ((rd_present && r_cnt == LCNT_W'(RESULT_LIMIT - 1)) || col_last) begin
                        n_state = S_LIST_END;
                    end else begin
                        n_col   = r_col + VTX_W'(1);
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_LIST_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out_item = '{vertex_a: r_pend_col, vertex_b: '0,
                                       weight_out: r_pend_w, found: 1'b1, last: 1'b1};
                    end else begin
                        n_out_item = '{vertex_a: '0, vertex_b: '0, weight_out: '0,
                                       found: 1'b0, last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{vertex_a: '0, vertex_b: '0, weight_out: '0,
                                    found: r_resp_found, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_QUERY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_min_present) begin
                        n_out_item = '{vertex_a: '0, vertex_b: '0, weight_out: '0,
                                       found: 1'b0, last: 1'b1};
                    end else if (r_min_first < r_min_second) begin
                        n_out_item = '{vertex_a: r_min_first, vertex_b: r_min_second,
                                       weight_out: r_min_weight, found: 1'b1,
                                       last: 1'b1};
                    end else begin
                        n_out_item = '{vertex_a: r_min_second, vertex_b: r_min_first,
                                       weight_out: r_min_weight, found: 1'b1,
                                       last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (wr_done) begin
            if (r_cmd == CMD_REMOVE && wr_hit) begin
                // removed the minimum: start a full rescan
                n_min_present = 1'b0;
                n_min_first   = '0;
                n_min_second  = '0;
                n_min_weight  = '0;
                n_row         = '0;
                n_col         = '0;
                n_state       = S_SCAN_RD;
            end else begin
                n_resp_found = 1'b1;
                n_state      = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_min_first   <= '0;
            r_min_second  <= '0;
            r_min_weight  <= '0;
            r_min_present <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_out_valid   <= n_out_valid;
            r_min_first   <= n_min_first;
            r_min_second  <= n_min_second;
            r_min_weight  <= n_min_weight;
            r_min_present <= n_min_present;
            r_pend_valid  <= n_pend_valid;
            r_cnt         <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_v1         <= n_v1;
        r_v2         <= n_v2;
        r_w          <= n_w;
        r_row        <= n_row;
        r_col        <= n_col;
        r_pend_col   <= n_pend_col;
        r_pend_w     <= n_pend_w;
        r_hit        <= n_hit;
        r_resp_found <= n_resp_found;
        r_out_item   <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_vcount   <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIRECTED:     r_directed <= i_cfg_data[0];
                CFG_VERTEX_COUNT: r_vcount   <= i_cfg_data;
                default:          r_directed <= r_directed;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/amt_checker.sv */
// port level checks for the adjacency matrix minimum edge tracker
module amt_checker
    import amt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // no result and no intake right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open after reset");

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // one item at a time: intake closes after an accepted item
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous item in progress");

    // an empty result is all zero and closes its item
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |->
            o_out_item.last && o_out_item.vertex_a == '0 &&
            o_out_item.vertex_b == '0 && o_out_item.weight_out == '0)
        else $error("empty result carries data");

    // a result that is not last must be a neighbour entry
    a_nonlast_is_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |->
            o_out_item.found && o_out_item.vertex_b == '0)
        else $error("non-final result is not a neighbour entry");

endmodule

bind adjacency_matrix_min_edge_tracker amt_checker u_amt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

/* verif/amt_edge_checker.sv */
// checker for the min edge tracker: watches both channels, predicts results and compares them
`timescale 1ns / 100ps

module amt_edge_checker
    import amt_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [VCNT_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;

    logic [ENTRY_W-1:0] edge_cells [CELLS];
    logic [VTX_W-1:0]   min_a_q;
    logic [VTX_W-1:0]   min_b_q;
    logic [WGT_W-1:0]   min_w_q;
    logic               min_held;
    logic               is_directed;
    logic [VCNT_W-1:0]  vcount;
    t_out_item          expected_results [$];
    int                 fails = 0;

    function automatic int active_size();
        return (int'(vcount) < MAX_VERTICES) ? int'(vcount) : MAX_VERTICES;
    endfunction

    function automatic void push_result(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                        input logic [WGT_W-1:0] w, input logic found,
                                        input logic last);
        t_out_item r;
        r.vertex_a   = a;
        r.vertex_b   = b;
        r.weight_out = w;
        r.found      = found;
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // row-major walk, first strictly smallest present edge wins
    function automatic void rescan_minimum();
        int n;
        logic [ENTRY_W-1:0] e;
        n = active_size();
        min_held = 1'b0;
        min_a_q  = '0;
        min_b_q  = '0;
        min_w_q  = '0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                e = edge_cells[r * MAX_VERTICES + c];
                if (e[ENTRY_W-1] && (!min_held || e[WGT_W-1:0] < min_w_q)) begin
                    min_held = 1'b1;
                    min_w_q  = e[WGT_W-1:0];
                    min_a_q  = VTX_W'(r);
                    min_b_q  = VTX_W'(c);
                end
            end
        end
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < CELLS; i++) edge_cells[i] = '0;
        min_a_q     = '0;
        min_b_q     = '0;
        min_w_q     = '0;
        min_held    = 1'b0;
        is_directed = 1'b0;
        vcount      = VCOUNT_RESET;
        expected_results.delete();
    endfunction

    function automatic void predict_item(input t_in_item it);
        int n;
        int fi;
        int ti;
        int total;
        int k;
        logic [ENTRY_W-1:0] e;
        n  = active_size();
        fi = int'(it.from_vertex);
        ti = int'(it.to_vertex);
        case (it.command)
            CMD_ADD, CMD_REMOVE: begin
                if (fi >= n || ti >= n) begin
                    push_result('0, '0, '0, 1'b0, 1'b1);
                end else if (it.command == CMD_ADD) begin
                    edge_cells[fi * MAX_VERTICES + ti] = {1'b1, it.edge_weight};
                    if (!is_directed) edge_cells[ti * MAX_VERTICES + fi] = {1'b1, it.edge_weight};
                    if (!min_held || it.edge_weight <= min_w_q) begin
                        min_held = 1'b1;
                        min_a_q  = it.from_vertex;
                        min_b_q  = it.to_vertex;
                        min_w_q  = it.edge_weight;
                    end
                    push_result('0, '0, '0, 1'b1, 1'b1);
                end else begin
                    edge_cells[fi * MAX_VERTICES + ti] = '0;
                    if (!is_directed) edge_cells[ti * MAX_VERTICES + fi] = '0;
                    // either order of the pair hits the record
                    if (min_held &&
                        ((it.from_vertex == min_a_q && it.to_vertex == min_b_q) ||
                         (it.to_vertex == min_a_q && it.from_vertex == min_b_q)))
                        rescan_minimum();
                    push_result('0, '0, '0, 1'b1, 1'b1);
                end
            end
            CMD_QUERY: begin
                if (!min_held)
                    push_result('0, '0, '0, 1'b0, 1'b1);
                else if (min_a_q < min_b_q)
                    push_result(min_a_q, min_b_q, min_w_q, 1'b1, 1'b1);
                else
                    push_result(min_b_q, min_a_q, min_w_q, 1'b1, 1'b1);
            end
            default: begin
                total = 0;
                if (fi < n) begin
                    for (int c = 0; c < n; c++)
                        if (edge_cells[fi * MAX_VERTICES + c][ENTRY_W-1]) total++;
                end
                if (total > RESULT_LIMIT) total = RESULT_LIMIT;
                if (total == 0) begin
                    push_result('0, '0, '0, 1'b0, 1'b1);
                end else begin
                    k = 0;
                    for (int c = 0; c < n && k < total; c++) begin
                        e = edge_cells[fi * MAX_VERTICES + c];
                        if (e[ENTRY_W-1]) begin
                            k++;
                            push_result(VTX_W'(c), '0, e[WGT_W-1:0], 1'b1, k == total);
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            if (fails < 10)
                $display("unexpected item: a=%0d b=%0d w=%0d found=%0b last=%0b",
                         got.vertex_a, got.vertex_b, got.weight_out, got.found, got.last);
            fails++;
        end else begin
            want = expected_results.pop_front();
            if (got.vertex_a !== want.vertex_a || got.vertex_b !== want.vertex_b ||
                got.weight_out !== want.weight_out || got.found !== want.found ||
                got.last !== want.last) begin
                if (fails < 10)
                    $display("mismatch: expected a=%0d b=%0d w=%0d found=%0b last=%0b, %s",
                             want.vertex_a, want.vertex_b, want.weight_out, want.found,
                             want.last, $sformatf("got a=%0d b=%0d w=%0d found=%0b last=%0b",
                             got.vertex_a, got.vertex_b, got.weight_out, got.found,
                             got.last));
                fails++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DIRECTED) is_directed = i_cfg_data[0];
                else vcount = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_item);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

/* verif/tb_adjacency_matrix_min_edge_tracker.sv */
// testbench top for the min edge tracker: stimulus, idling, watchdog and verdict
`timescale 1ns / 100ps

module tb_adjacency_matrix_min_edge_tracker;
    import amt_pkg::*;

    localparam int MAX_V       = 16;
    localparam int STALL_LIMIT = 5000;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_we;
    logic              cfg_index;
    logic [VCNT_W-1:0] cfg_data;
    int                fail_count;
    int                pending;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                active_n = MAX_V;
    int                quiet_cycles = 0;
    logic [11:0]       added_pairs [$];

    adjacency_matrix_min_edge_tracker #(
        .MAX_VERTICES(MAX_V)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    amt_edge_checker #(
        .MAX_VERTICES(MAX_V)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // counts cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input t_cmd cmd, input int f, input int t,
                                           input logic [WGT_W-1:0] w);
        t_in_item it;
        it.command     = cmd;
        it.from_vertex = VTX_W'(f);
        it.to_vertex   = VTX_W'(t);
        it.edge_weight = w;
        return it;
    endfunction

    function automatic logic [VTX_W-1:0] pick_vertex();
        if (active_n == 0 || $urandom_range(0, 9) == 0) return VTX_W'($urandom_range(0, 63));
        return VTX_W'($urandom_range(0, active_n - 1));
    endfunction

    // mostly in-range updates with small weights so ties and rescans happen often
    function automatic t_in_item random_item();
        t_in_item    it;
        int          roll;
        int          idx;
        logic [11:0] p;
        roll = $urandom_range(0, 99);
        it.from_vertex = pick_vertex();
        it.to_vertex   = pick_vertex();
        if ($urandom_range(0, 3) == 0) it.edge_weight = WGT_W'($urandom());
        else it.edge_weight = WGT_W'($urandom_range(0, 20));
        if (roll < 40) begin
            it.command = CMD_ADD;
            added_pairs.push_back({it.from_vertex, it.to_vertex});
            if (added_pairs.size() > 32) void'(added_pairs.pop_front());
        end else if (roll < 65) begin
            it.command = CMD_REMOVE;
            if (added_pairs.size() != 0 && $urandom_range(0, 9) < 7) begin
                idx = $urandom_range(0, added_pairs.size() - 1);
                p   = added_pairs[idx];
                if ($urandom_range(0, 1) == 0) begin
                    it.from_vertex = p[11:6];
                    it.to_vertex   = p[5:0];
                end else begin
                    it.from_vertex = p[5:0];
                    it.to_vertex   = p[11:6];
                end
            end
        end else if (roll < 80) begin
            it.command = CMD_QUERY;
        end else begin
            it.command = CMD_LIST;
        end
        return it;
    endfunction

    // all stimulus tasks start and end at a falling edge
    task automatic send_item(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [VCNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic dir, input logic [VCNT_W-1:0] vcnt);
        drain_results();
        write_reg(CFG_DIRECTED, {{(VCNT_W-1){1'b0}}, dir});
        write_reg(CFG_VERTEX_COUNT, vcnt);
        active_n = (int'(vcnt) < MAX_V) ? int'(vcnt) : MAX_V;
    endtask

    task automatic run_phase(input int idle, input int stall, input logic dir,
                             input logic [VCNT_W-1:0] vcnt, input int count);
        configure(dir, vcnt);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(1'b0, 7'd16);
        send_item(make_item(CMD_QUERY, 0, 0, '0));           // nothing recorded yet
        send_item(make_item(CMD_LIST, 0, 0, '0));            // empty row
        send_item(make_item(CMD_ADD, 0, 15, 31'h7fffffff));
        send_item(make_item(CMD_ADD, 3, 5, 31'd100));
        send_item(make_item(CMD_ADD, 5, 3, 31'd100));        // equal weight takes over
        send_item(make_item(CMD_QUERY, 0, 0, '0));
        send_item(make_item(CMD_ADD, 2, 2, 31'd0));
        send_item(make_item(CMD_QUERY, 63, 63, 31'h7fffffff));
        send_item(make_item(CMD_ADD, 16, 1, 31'd9));         // endpoint out of range
        send_item(make_item(CMD_REMOVE, 1, 63, '0));
        send_item(make_item(CMD_LIST, 3, 0, '0));
        send_item(make_item(CMD_LIST, 16, 0, '0));
        send_item(make_item(CMD_LIST, 63, 63, '0));
        send_item(make_item(CMD_ADD, 2, 2, 31'd500));        // record goes stale
        send_item(make_item(CMD_QUERY, 0, 0, '0));
        send_item(make_item(CMD_REMOVE, 2, 2, '0));
        send_item(make_item(CMD_QUERY, 0, 0, '0));
        send_item(make_item(CMD_REMOVE, 3, 5, '0));          // same pair as the rescanned record
        send_item(make_item(CMD_QUERY, 0, 0, '0));           // max weight edge survives

        configure(1'b1, 7'd16);
        send_item(make_item(CMD_ADD, 4, 9, 31'd1));
        send_item(make_item(CMD_REMOVE, 9, 4, '0));          // directed reversed pair rescans
        send_item(make_item(CMD_QUERY, 0, 0, '0));
        send_item(make_item(CMD_LIST, 4, 0, '0));

        configure(1'b0, 7'd1);
        send_item(make_item(CMD_ADD, 0, 0, 31'd7));
        send_item(make_item(CMD_ADD, 0, 1, 31'd3));

        run_phase(83, 0, 1'b1, 7'd16, 35);
        run_phase(0, 83, 1'b0, 7'd5, 35);
        run_phase(22, 22, 1'b1, 7'd1, 15);
        run_phase(0, 0, 1'b0, 7'd127, 30);
        run_phase(83, 0, 1'b0, 7'd0, 10);
        run_phase(0, 83, 1'b1, 7'd64, 30);
        run_phase(22, 22, 1'b0, 7'd3, 25);
        run_phase(0, 0, 1'b1, 7'd16, 20);

        drain_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
